// File: design/hbp_pkg.sv
// ----------------------------------------------------------------------------
// hbp_pkg
// Shared types, codes and helpers for the hybrid branch predictor.
// ----------------------------------------------------------------------------
package hbp_pkg;

  localparam int CtrW     = 2;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 4;
  localparam int ModeW    = 2;

  localparam logic [ModeW-1:0] MODE_BIMODAL = 2'd0;
  localparam logic [ModeW-1:0] MODE_GSHARE  = 2'd1;
  localparam logic [ModeW-1:0] MODE_HYBRID  = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_MODE         = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_GSHARE_BITS  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_HISTORY_BITS = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_BIMODAL_BITS = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_CHOOSER_BITS = 3'd4;

  localparam logic [CfgDataW-1:0] RST_GSHARE_BITS  = 4'd14;
  localparam logic [CfgDataW-1:0] RST_HISTORY_BITS = 4'd8;
  localparam logic [CfgDataW-1:0] RST_BIMODAL_BITS = 4'd14;
  localparam logic [CfgDataW-1:0] RST_CHOOSER_BITS = 4'd14;

  localparam logic [CtrW-1:0] CTR_WEAK_TAKEN   = 2'd2;
  localparam logic [CtrW-1:0] CHOOSE_WEAK_BIM  = 2'd1;
  localparam logic [CtrW-1:0] CTR_MAX          = 2'd3;
  localparam logic [CtrW-1:0] CTR_MIN          = 2'd0;

  typedef logic [CtrW-1:0] ctr_t;

  function automatic ctr_t sat_train(input ctr_t c, input logic up);
    ctr_t r;
    r = c;
    if (up) begin
      if (c != CTR_MAX) r = c + ctr_t'(1);
    end else begin
      if (c != CTR_MIN) r = c - ctr_t'(1);
    end
    return r;
  endfunction

  function automatic logic ctr_high(input ctr_t c);
    return c[CtrW-1];
  endfunction

endpackage

// File: design/hbp_front.sv
// ----------------------------------------------------------------------------
// hbp_front
// Configuration registers, global history and table index generation.
// ----------------------------------------------------------------------------
module hbp_front import hbp_pkg::*; #(
  parameter int MAX_GSHARE_BITS  = 14,
  parameter int MAX_BIMODAL_BITS = 14,
  parameter int MAX_CHOOSER_BITS = 14
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CfgIdxW-1:0]          cfg_idx_i,
  input  logic [CfgDataW-1:0]         cfg_data_i,
  input  logic                        push_i,
  input  logic [31:0]                 branch_pc_i,
  input  logic                        taken_i,
  output logic [MAX_GSHARE_BITS-1:0]  gidx_o,
  output logic [MAX_BIMODAL_BITS-1:0] bidx_o,
  output logic [MAX_CHOOSER_BITS-1:0] cidx_o,
  output logic [ModeW-1:0]            mode_o
);

  localparam int GW = $clog2(MAX_GSHARE_BITS + 1);
  localparam int BW = $clog2(MAX_BIMODAL_BITS + 1);
  localparam int KW = $clog2(MAX_CHOOSER_BITS + 1);

  logic [ModeW-1:0]            mode_q;
  logic [CfgDataW-1:0]         gsh_bits_q, hist_bits_q, bim_bits_q, cho_bits_q;
  logic [MAX_GSHARE_BITS-1:0]  history_q, history_d;
  logic [GW-1:0]               m1, n;
  logic [BW-1:0]               m2;
  logic [KW-1:0]               k;
  logic [MAX_GSHARE_BITS-1:0]  g_mask, h_mask, hist, g_word;
  logic [MAX_BIMODAL_BITS-1:0] b_mask;
  logic [MAX_CHOOSER_BITS-1:0] c_mask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_HYBRID;
      gsh_bits_q  <= RST_GSHARE_BITS;
      hist_bits_q <= RST_HISTORY_BITS;
      bim_bits_q  <= RST_BIMODAL_BITS;
      cho_bits_q  <= RST_CHOOSER_BITS;
      history_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MODE:         mode_q      <= cfg_data_i[ModeW-1:0];
          CFG_GSHARE_BITS:  gsh_bits_q  <= cfg_data_i;
          CFG_HISTORY_BITS: hist_bits_q <= cfg_data_i;
          CFG_BIMODAL_BITS: bim_bits_q  <= cfg_data_i;
          CFG_CHOOSER_BITS: cho_bits_q  <= cfg_data_i;
          default: ;
        endcase
      end
      history_q <= history_d;
    end
  end

  // clamp index widths to 1..max
  always_comb begin
    if (gsh_bits_q == '0) begin
      m1 = GW'(1);
    end else if (32'(gsh_bits_q) > MAX_GSHARE_BITS) begin
      m1 = GW'(MAX_GSHARE_BITS);
    end else begin
      m1 = GW'(gsh_bits_q);
    end
    if (32'(hist_bits_q) > 32'(m1)) begin
      n = m1;
    end else begin
      n = GW'(hist_bits_q);
    end
    if (bim_bits_q == '0) begin
      m2 = BW'(1);
    end else if (32'(bim_bits_q) > MAX_BIMODAL_BITS) begin
      m2 = BW'(MAX_BIMODAL_BITS);
    end else begin
      m2 = BW'(bim_bits_q);
    end
    if (cho_bits_q == '0) begin
      k = KW'(1);
    end else if (32'(cho_bits_q) > MAX_CHOOSER_BITS) begin
      k = KW'(MAX_CHOOSER_BITS);
    end else begin
      k = KW'(cho_bits_q);
    end
  end

  assign g_mask = {MAX_GSHARE_BITS{1'b1}} >> (GW'(MAX_GSHARE_BITS) - m1);
  assign h_mask = {MAX_GSHARE_BITS{1'b1}} >> (GW'(MAX_GSHARE_BITS) - n);
  assign b_mask = {MAX_BIMODAL_BITS{1'b1}} >> (BW'(MAX_BIMODAL_BITS) - m2);
  assign c_mask = {MAX_CHOOSER_BITS{1'b1}} >> (KW'(MAX_CHOOSER_BITS) - k);
  assign hist   = history_q & h_mask;
  assign g_word = branch_pc_i[2 +: MAX_GSHARE_BITS];

  assign gidx_o = (g_word & g_mask) ^ (hist << (m1 - n));
  assign bidx_o = branch_pc_i[2 +: MAX_BIMODAL_BITS] & b_mask;
  assign cidx_o = branch_pc_i[2 +: MAX_CHOOSER_BITS] & c_mask;
  assign mode_o = mode_q;

  // history shifts in the outcome at the top of the n-bit window
  always_comb begin
    history_d = history_q;
    if (push_i && mode_q != MODE_BIMODAL && n != '0) begin
      history_d = (hist >> 1) | (MAX_GSHARE_BITS'(taken_i) << (n - GW'(1)));
    end
  end

endmodule

// File: design/hbp_fifo.sv
// ----------------------------------------------------------------------------
// hbp_fifo
// Two-entry queue between the index front end and the table back end.
// ----------------------------------------------------------------------------
module hbp_fifo import hbp_pkg::*; #(
  parameter int DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              pop_i,
  output logic [DATA_W-1:0] rdata_o,
  output logic              full_o,
  output logic              empty_o
);

  logic [DATA_W-1:0] mem_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        count_q, count_d;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= wdata_i;
  end

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) count_d = count_q + 2'd1;
    if (pop_i && !push_i) count_d = count_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_d;
    end
  end

  assign rdata_o = mem_q[rd_ptr_q];
  assign full_o  = count_q[1];
  assign empty_o = (count_q == 2'd0);

endmodule

// File: design/hbp_back.sv
// ----------------------------------------------------------------------------
// hbp_back
// Counter tables: clearing pass, read, train and write, result register.
// ----------------------------------------------------------------------------
module hbp_back import hbp_pkg::*; #(
  parameter int MAX_GSHARE_BITS  = 14,
  parameter int MAX_BIMODAL_BITS = 14,
  parameter int MAX_CHOOSER_BITS = 14
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_empty_i,
  output logic                        pop_o,
  input  logic [MAX_GSHARE_BITS-1:0]  gidx_i,
  input  logic [MAX_BIMODAL_BITS-1:0] bidx_i,
  input  logic [MAX_CHOOSER_BITS-1:0] cidx_i,
  input  logic [ModeW-1:0]            mode_i,
  input  logic                        taken_i,
  output logic                        init_done_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        predicted_taken_o,
  output logic                        mispredicted_o
);

  localparam int GB = (MAX_GSHARE_BITS > MAX_BIMODAL_BITS) ? MAX_GSHARE_BITS
                                                             : MAX_BIMODAL_BITS;
  localparam int CW = (GB > MAX_CHOOSER_BITS) ? GB : MAX_CHOOSER_BITS;

  ctr_t g_mem [2**MAX_GSHARE_BITS];
  ctr_t b_mem [2**MAX_BIMODAL_BITS];
  ctr_t c_mem [2**MAX_CHOOSER_BITS];

  logic                        clearing_q;
  logic [CW-1:0]               clr_idx_q;
  logic                        busy_q;
  logic [MAX_GSHARE_BITS-1:0]  gidx_q;
  logic [MAX_BIMODAL_BITS-1:0] bidx_q;
  logic [MAX_CHOOSER_BITS-1:0] cidx_q;
  logic [ModeW-1:0]            mode_q;
  logic                        taken_q;
  ctr_t                        g_rd_q, b_rd_q, c_rd_q;
  logic                        out_valid_q, pred_q, misp_q;

  logic                        finish;
  logic                        gpred, bpred, use_g, pred;
  logic                        g_we, b_we, c_we;
  logic [MAX_GSHARE_BITS-1:0]  g_wa;
  logic [MAX_BIMODAL_BITS-1:0] b_wa;
  logic [MAX_CHOOSER_BITS-1:0] c_wa;
  ctr_t                        g_wd, b_wd, c_wd;

  assign pop_o  = !clearing_q && !busy_q && !q_empty_i;
  assign finish = busy_q && (!out_valid_q || out_ready_i);

  assign gpred = ctr_high(g_rd_q);
  assign bpred = ctr_high(b_rd_q);
  assign use_g = ctr_high(c_rd_q);

  always_comb begin
    case (mode_q)
      MODE_BIMODAL: pred = bpred;
      MODE_GSHARE:  pred = gpred;
      default:      pred = use_g ? gpred : bpred;
    endcase
  end

  always_comb begin
    g_we = 1'b0;
    b_we = 1'b0;
    c_we = 1'b0;
    g_wa = gidx_q;
    b_wa = bidx_q;
    c_wa = cidx_q;
    g_wd = sat_train(g_rd_q, taken_q);
    b_wd = sat_train(b_rd_q, taken_q);
    c_wd = sat_train(c_rd_q, gpred == taken_q);
    if (clearing_q) begin
      g_we = 1'b1;
      b_we = 1'b1;
      c_we = 1'b1;
      g_wa = clr_idx_q[MAX_GSHARE_BITS-1:0];
      b_wa = clr_idx_q[MAX_BIMODAL_BITS-1:0];
      c_wa = clr_idx_q[MAX_CHOOSER_BITS-1:0];
      g_wd = CTR_WEAK_TAKEN;
      b_wd = CTR_WEAK_TAKEN;
      c_wd = CHOOSE_WEAK_BIM;
    end else if (finish) begin
      case (mode_q)
        MODE_BIMODAL: b_we = 1'b1;
        MODE_GSHARE:  g_we = 1'b1;
        default: begin
          g_we = use_g;
          b_we = !use_g;
          c_we = (gpred != bpred);
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (g_we) g_mem[g_wa] <= g_wd;
    if (pop_o) g_rd_q <= g_mem[gidx_i];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) b_mem[b_wa] <= b_wd;
    if (pop_o) b_rd_q <= b_mem[bidx_i];
  end

  always_ff @(posedge clk_i) begin
    if (c_we) c_mem[c_wa] <= c_wd;
    if (pop_o) c_rd_q <= c_mem[cidx_i];
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      gidx_q  <= gidx_i;
      bidx_q  <= bidx_i;
      cidx_q  <= cidx_i;
      mode_q  <= mode_i;
      taken_q <= taken_i;
    end
    if (finish) begin
      pred_q <= pred;
      misp_q <= pred != taken_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q  <= 1'b1;
      clr_idx_q   <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (clearing_q) begin
        clr_idx_q <= clr_idx_q + CW'(1);
        if (&clr_idx_q) clearing_q <= 1'b0;
      end
      if (pop_o) begin
        busy_q <= 1'b1;
      end else if (finish) begin
        busy_q <= 1'b0;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign init_done_o       = !clearing_q;
  assign out_valid_o       = out_valid_q;
  assign predicted_taken_o = pred_q;
  assign mispredicted_o    = misp_q;

endmodule

// File: design/hybrid_branch_predictor.sv
// ----------------------------------------------------------------------------
// hybrid_branch_predictor
// Tournament predictor: bimodal and gshare counter tables with a chooser.
// ----------------------------------------------------------------------------
// Takes one resolved branch per transfer and returns one prediction transfer
// with the prediction made before training and a mispredict flag. The front
// end computes table indices and updates the global history as the branch is
// taken in, so it runs ahead of the tables through a two-entry queue. The back
// end handles one branch at a time: it reads the three single-port counter
// tables, then trains and writes back once the result register is free, and
// takes the next branch only after that. After reset the tables are swept to
// their initial values, one entry per cycle over 2**max(MAX_GSHARE_BITS,
// MAX_BIMODAL_BITS, MAX_CHOOSER_BITS) entries (16384 at the defaults); no
// branch is taken in during that sweep, while register writes are. The user
// must write registers only when no branch is in flight; not enforced here.
// ----------------------------------------------------------------------------
module hybrid_branch_predictor import hbp_pkg::*; #(
  parameter int MAX_GSHARE_BITS  = 14,
  parameter int MAX_BIMODAL_BITS = 14,
  parameter int MAX_CHOOSER_BITS = 14
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [31:0]         branch_pc_i,
  input  logic                taken_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                predicted_taken_o,
  output logic                mispredicted_o
);

  localparam int EntryW = ModeW + 1 + MAX_CHOOSER_BITS + MAX_BIMODAL_BITS
                          + MAX_GSHARE_BITS;

  logic                        push, pop, q_full, q_empty, init_done;
  logic [MAX_GSHARE_BITS-1:0]  f_gidx, b_gidx;
  logic [MAX_BIMODAL_BITS-1:0] f_bidx, b_bidx;
  logic [MAX_CHOOSER_BITS-1:0] f_cidx, b_cidx;
  logic [ModeW-1:0]            f_mode, b_mode;
  logic                        b_taken;
  logic [EntryW-1:0]           q_wdata, q_rdata;

  assign in_ready_o = init_done && !q_full;
  assign push       = in_valid_i && in_ready_o;

  hbp_front #(
    .MAX_GSHARE_BITS (MAX_GSHARE_BITS),
    .MAX_BIMODAL_BITS(MAX_BIMODAL_BITS),
    .MAX_CHOOSER_BITS(MAX_CHOOSER_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push_i     (push),
    .branch_pc_i(branch_pc_i),
    .taken_i    (taken_i),
    .gidx_o     (f_gidx),
    .bidx_o     (f_bidx),
    .cidx_o     (f_cidx),
    .mode_o     (f_mode)
  );

  assign q_wdata = {f_mode, taken_i, f_cidx, f_bidx, f_gidx};

  hbp_fifo #(
    .DATA_W(EntryW)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(q_wdata),
    .pop_i  (pop),
    .rdata_o(q_rdata),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  assign {b_mode, b_taken, b_cidx, b_bidx, b_gidx} = q_rdata;

  hbp_back #(
    .MAX_GSHARE_BITS (MAX_GSHARE_BITS),
    .MAX_BIMODAL_BITS(MAX_BIMODAL_BITS),
    .MAX_CHOOSER_BITS(MAX_CHOOSER_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .pop_o            (pop),
    .gidx_i           (b_gidx),
    .bidx_i           (b_bidx),
    .cidx_i           (b_cidx),
    .mode_i           (b_mode),
    .taken_i          (b_taken),
    .init_done_o      (init_done),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .predicted_taken_o(predicted_taken_o),
    .mispredicted_o   (mispredicted_o)
  );

endmodule
